FILE: design/barw_pkg.sv
package barw_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF       = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // Every weight is a signed 32-bit word.
  localparam int W_BITS = 32;

  // Quotient magnitude bits below the saturation point.
  localparam int Q_BITS = W_BITS - 1;

  // Divider pipeline depth: overflow check, one stage per quotient bit, sign and clip.
  localparam int DIV_LAT = Q_BITS + 2;

  localparam logic signed [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
  localparam logic signed [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};

endpackage

FILE: design/barw_if.sv
interface barw_in_if
  import barw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vert_a_x;
  logic signed [COORD_BITS-1:0] vert_a_y;
  logic signed [COORD_BITS-1:0] vert_b_x;
  logic signed [COORD_BITS-1:0] vert_b_y;
  logic signed [COORD_BITS-1:0] vert_c_x;
  logic signed [COORD_BITS-1:0] vert_c_y;

  modport source (
    output valid, point_x, point_y, vert_a_x, vert_a_y,
           vert_b_x, vert_b_y, vert_c_x, vert_c_y,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, vert_a_x, vert_a_y,
           vert_b_x, vert_b_y, vert_c_x, vert_c_y,
    output ready
  );
endinterface

interface barw_out_if
  import barw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [W_BITS-1:0] weight_a;
  logic signed [W_BITS-1:0] weight_b;
  logic signed [W_BITS-1:0] weight_c;
  logic                     degenerate;

  modport source (
    output valid, weight_a, weight_b, weight_c, degenerate,
    input  ready
  );

  modport sink (
    input  valid, weight_a, weight_b, weight_c, degenerate,
    output ready
  );
endinterface

FILE: design/barw_div.sv
module barw_div
  import barw_pkg::*;
#(
  parameter int MAG_BITS         = 2 * COORD_BITS_DEF + 3,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [MAG_BITS-1:0]      num_mag,
  input  logic [MAG_BITS-1:0]      den_mag,
  input  logic                     neg,
  output logic signed [W_BITS-1:0] quot
);

  localparam int EXT_BITS = MAG_BITS + Q_BITS;

  logic [EXT_BITS-1:0] ext;
  logic [MAG_BITS-1:0] rem0;

  logic [MAG_BITS-1:0] rem_r  [0:Q_BITS-1];
  logic [Q_BITS-1:0]   low_r  [0:Q_BITS-1];
  logic [MAG_BITS-1:0] den_r  [0:Q_BITS];
  logic                neg_r  [0:Q_BITS];
  logic                ovf_r  [0:Q_BITS];
  logic [Q_BITS-1:0]   q_r    [1:Q_BITS];

  logic [MAG_BITS:0]   trial  [1:Q_BITS];
  logic                ge     [1:Q_BITS];
  logic [MAG_BITS-1:0] rem_nxt[1:Q_BITS];

  logic signed [W_BITS-1:0] quot_nxt;
  logic signed [W_BITS-1:0] quot_r;

  // The dividend is num_mag scaled by the fraction bits. Its bits above the
  // quotient range form the starting remainder; if that already reaches the
  // divisor, the quotient cannot fit and the weight saturates.
  always_comb begin
    ext  = {{Q_BITS{1'b0}}, num_mag} << WEIGHT_FRAC_BITS;
    rem0 = ext[Q_BITS +: MAG_BITS];
  end

  always_comb begin
    for (int k = 1; k <= Q_BITS; k++) begin
      trial[k]   = {rem_r[k-1], low_r[k-1][Q_BITS-1]};
      ge[k]      = trial[k] >= {1'b0, den_r[k-1]};
      rem_nxt[k] = ge[k] ? MAG_BITS'(trial[k] - {1'b0, den_r[k-1]})
                         : MAG_BITS'(trial[k]);
    end
  end

  always_comb begin
    if (ovf_r[Q_BITS]) begin
      quot_nxt = neg_r[Q_BITS] ? W_MIN : W_MAX;
    end else if (neg_r[Q_BITS]) begin
      quot_nxt = W_BITS'(-signed'({1'b0, q_r[Q_BITS]}));
    end else begin
      quot_nxt = signed'({1'b0, q_r[Q_BITS]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      low_r[0] <= ext[Q_BITS-1:0];
      den_r[0] <= den_mag;
      neg_r[0] <= neg;
      ovf_r[0] <= rem0 >= den_mag;
      for (int k = 1; k <= Q_BITS; k++) begin
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
      q_r[1] <= {{(Q_BITS-1){1'b0}}, ge[1]};
      for (int k = 2; k <= Q_BITS; k++) begin
        q_r[k] <= {q_r[k-1][Q_BITS-2:0], ge[k]};
      end
      for (int k = 1; k < Q_BITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_r[k-1] << 1;
      end
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

FILE: design/triangle_barycentric_weights_core.sv
// Barycentric weights of a query point against a triangle.
// The input channel in_ch carries the point and the three vertices as signed
// fixed-point coordinates with four fraction bits; the output channel out_ch
// carries the three weights with WEIGHT_FRAC_BITS fraction bits, saturated
// to 32 bits, and a flag for a triangle of zero area, whose weights are zero.
// Both channels move an item on a clock edge at which valid and ready are high.
// The datapath is a pipeline of DIV_LAT + 5 stages: differences, products,
// cross products, magnitudes, a restoring divider with one quotient bit per
// stage for each of the two ratios, and the sum for the first weight, followed
// by the output register. One item is taken every cycle unless the pipeline
// is halted by a held-off result.
// When the receiver holds off, the output register keeps its item and the
// pipeline still advances until a finished result reaches its last stage;
// only then does in_ch.ready fall, and nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit, that of the output
// register too; no item is in flight afterwards.
module triangle_barycentric_weights_core
  import barw_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  barw_in_if.sink       in_ch,
  barw_out_if.source    out_ch
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * COORD_BITS + 2;
  localparam int XW  = 2 * COORD_BITS + 3;
  localparam int NST = 4 + DIV_LAT + 1;
  localparam int SW  = W_BITS + 2;

  localparam logic signed [SW-1:0] ONE_W   = SW'(64'sd1 <<< WEIGHT_FRAC_BITS);
  localparam logic signed [SW-1:0] W_MAX_X = SW'(W_MAX);
  localparam logic signed [SW-1:0] W_MIN_X = SW'(W_MIN);

  logic en;
  logic v_r [0:NST-1];

  logic signed [DW-1:0] dpx_r, dpy_r, dbx_r, dby_r, dcx_r, dcy_r;
  logic signed [PW-1:0] pd1_r, pd2_r, pb1_r, pb2_r, pc1_r, pc2_r;
  logic signed [XW-1:0] den_r, numb_r, numc_r;

  logic [XW-1:0] den_mag_nxt, numb_mag_nxt, numc_mag_nxt;
  logic [XW-1:0] den_mag_r, numb_mag_r, numc_mag_r;
  logic          negb_r, negc_r;
  logic          deg_r [0:DIV_LAT];

  logic signed [W_BITS-1:0] wb, wc;
  logic signed [SW-1:0]     wa_sum;
  logic signed [W_BITS-1:0] wa_nxt;
  logic signed [W_BITS-1:0] wa_r, wb_r, wc_r;
  logic                     dg_r;

  logic                     out_valid_r;
  logic signed [W_BITS-1:0] out_wa_r, out_wb_r, out_wc_r;
  logic                     out_dg_r;
  logic                     out_load;

  // The pipeline only halts when a finished result cannot move into a full,
  // untaken output register.
  assign out_load = !out_valid_r || out_ch.ready;
  assign en       = !(v_r[NST-1] && !out_load);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_comb begin
    den_mag_nxt  = den_r[XW-1]  ? XW'(-den_r)  : XW'(den_r);
    numb_mag_nxt = numb_r[XW-1] ? XW'(-numb_r) : XW'(numb_r);
    numc_mag_nxt = numc_r[XW-1] ? XW'(-numc_r) : XW'(numc_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx_r <= {in_ch.point_x[COORD_BITS-1], in_ch.point_x}
             - {in_ch.vert_a_x[COORD_BITS-1], in_ch.vert_a_x};
      dpy_r <= {in_ch.point_y[COORD_BITS-1], in_ch.point_y}
             - {in_ch.vert_a_y[COORD_BITS-1], in_ch.vert_a_y};
      dbx_r <= {in_ch.vert_b_x[COORD_BITS-1], in_ch.vert_b_x}
             - {in_ch.vert_a_x[COORD_BITS-1], in_ch.vert_a_x};
      dby_r <= {in_ch.vert_b_y[COORD_BITS-1], in_ch.vert_b_y}
             - {in_ch.vert_a_y[COORD_BITS-1], in_ch.vert_a_y};
      dcx_r <= {in_ch.vert_c_x[COORD_BITS-1], in_ch.vert_c_x}
             - {in_ch.vert_a_x[COORD_BITS-1], in_ch.vert_a_x};
      dcy_r <= {in_ch.vert_c_y[COORD_BITS-1], in_ch.vert_c_y}
             - {in_ch.vert_a_y[COORD_BITS-1], in_ch.vert_a_y};

      pd1_r <= PW'(dbx_r) * PW'(dcy_r);
      pd2_r <= PW'(dcx_r) * PW'(dby_r);
      pb1_r <= PW'(dpx_r) * PW'(dcy_r);
      pb2_r <= PW'(dcx_r) * PW'(dpy_r);
      pc1_r <= PW'(dpx_r) * PW'(dby_r);
      pc2_r <= PW'(dbx_r) * PW'(dpy_r);

      den_r  <= XW'(pd1_r) - XW'(pd2_r);
      numb_r <= XW'(pb1_r) - XW'(pb2_r);
      numc_r <= XW'(pc1_r) - XW'(pc2_r);

      den_mag_r  <= den_mag_nxt;
      numb_mag_r <= numb_mag_nxt;
      numc_mag_r <= numc_mag_nxt;
      // The second ratio divides by the negated area, which flips its sign.
      negb_r   <= numb_r[XW-1] != den_r[XW-1];
      negc_r   <= numc_r[XW-1] == den_r[XW-1];
      deg_r[0] <= den_r == '0;
      for (int k = 1; k <= DIV_LAT; k++) begin
        deg_r[k] <= deg_r[k-1];
      end
    end
  end

  barw_div #(
    .MAG_BITS         (XW),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div_b (
    .clk     (clk),
    .en      (en),
    .num_mag (numb_mag_r),
    .den_mag (den_mag_r),
    .neg     (negb_r),
    .quot    (wb)
  );

  barw_div #(
    .MAG_BITS         (XW),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div_c (
    .clk     (clk),
    .en      (en),
    .num_mag (numc_mag_r),
    .den_mag (den_mag_r),
    .neg     (negc_r),
    .quot    (wc)
  );

  always_comb begin
    wa_sum = ONE_W - SW'(wb) - SW'(wc);
    if (wa_sum > W_MAX_X) begin
      wa_nxt = W_MAX;
    end else if (wa_sum < W_MIN_X) begin
      wa_nxt = W_MIN;
    end else begin
      wa_nxt = W_BITS'(wa_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg_r <= deg_r[DIV_LAT];
      wa_r <= deg_r[DIV_LAT] ? '0 : wa_nxt;
      wb_r <= deg_r[DIV_LAT] ? '0 : wb;
      wc_r <= deg_r[DIV_LAT] ? '0 : wc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wa_r <= wa_r;
      out_wb_r <= wb_r;
      out_wc_r <= wc_r;
      out_dg_r <= dg_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.weight_a   = out_wa_r;
  assign out_ch.weight_b   = out_wb_r;
  assign out_ch.weight_c   = out_wc_r;
  assign out_ch.degenerate = out_dg_r;

endmodule

FILE: design/barw_chk.sv
module barw_chk
  import barw_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [W_BITS-1:0] weight_a,
  input logic signed [W_BITS-1:0] weight_b,
  input logic signed [W_BITS-1:0] weight_c,
  input logic                     degenerate
);

  localparam int SW = W_BITS + 2;
  localparam logic signed [SW-1:0] ONE_W = SW'(64'sd1 <<< WEIGHT_FRAC_BITS);

  logic signed [SW-1:0] w_sum;

  assign w_sum = SW'(weight_a) + SW'(weight_b) + SW'(weight_c);

  // A result that is held off stays as it is until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(weight_a) && $stable(weight_b)
      && $stable(weight_c) && $stable(degenerate))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input is refused only while a result waits at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stalled result");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> weight_a == '0 && weight_b == '0 && weight_c == '0)
    else $error("degenerate triangle with nonzero weights");

  // Unless the triangle is degenerate or the first weight clipped, the three weights sum to one.
  a_sum_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !degenerate && weight_a != W_MAX && weight_a != W_MIN
      |-> w_sum == ONE_W)
    else $error("weights do not sum to one");

endmodule

bind triangle_barycentric_weights_core barw_chk #(
  .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_barw_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .weight_a   (out_ch.weight_a),
  .weight_b   (out_ch.weight_b),
  .weight_c   (out_ch.weight_c),
  .degenerate (out_ch.degenerate)
);
